@@ hw/rtl/utf8c_pkg.sv @@
// Shared types and constants for the UTF-8 codec.
package utf8c_pkg;

    localparam int CP_W       = 31;
    localparam int BYTE_W     = 8;
    localparam int IDX_W      = 3;
    localparam int REM_W      = 3;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 40;

    localparam logic OP_ENCODE  = 1'b0;
    localparam logic OP_DECODE  = 1'b1;
    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_VALUE = 1'b1;

    // encode length thresholds
    localparam logic [CP_W-1:0] LIM_1 = 31'h0000_007F;
    localparam logic [CP_W-1:0] LIM_2 = 31'h0000_07FF;
    localparam logic [CP_W-1:0] LIM_3 = 31'h0000_FFFF;
    localparam logic [CP_W-1:0] LIM_4 = 31'h001F_FFFF;
    localparam logic [CP_W-1:0] LIM_5 = 31'h03FF_FFFF;

    localparam logic [BYTE_W-1:0] LEAD_2    = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD_3    = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD_4    = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD_5    = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD_6    = 8'hFC;
    localparam logic [BYTE_W-1:0] CONT_MARK = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD_END  = 8'hFD;
    localparam logic [BYTE_W-1:0] CONT_MASK = 8'h3F;

    localparam logic [IDX_W-1:0] ENC_MAX_BYTES = 3'd6;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } enc_byte_t;

    typedef struct packed {
        logic            has_result;
        logic [CP_W-1:0] value;
    } dec_result_t;

endpackage

@@ hw/rtl/utf8c_encoder.sv @@
// Encoder: picks one UTF-8 byte of a code point by byte position.
module utf8c_encoder
    import utf8c_pkg::*;
(
    input  logic [CP_W-1:0]  code_point,
    input  logic [IDX_W-1:0] idx,
    output enc_byte_t        enc
);

    logic [IDX_W-1:0]  len;
    logic [BYTE_W-1:0] lead;
    logic [IDX_W-1:0]  digit;
    logic [BYTE_W-1:0] chunk;

    always_comb begin
        if (code_point <= LIM_1) begin
            len = 3'd1; lead = '0;
        end else if (code_point <= LIM_2) begin
            len = 3'd2; lead = LEAD_2;
        end else if (code_point <= LIM_3) begin
            len = 3'd3; lead = LEAD_3;
        end else if (code_point <= LIM_4) begin
            len = 3'd4; lead = LEAD_4;
        end else if (code_point <= LIM_5) begin
            len = 3'd5; lead = LEAD_5;
        end else begin
            len = 3'd6; lead = LEAD_6;
        end
    end

    // six-bit digit number, counted from the low end
    assign digit = len - 3'd1 - idx;

    always_comb begin
        case (digit)
            3'd0:    chunk = code_point[7:0];
            3'd1:    chunk = code_point[13:6];
            3'd2:    chunk = code_point[19:12];
            3'd3:    chunk = code_point[25:18];
            3'd4:    chunk = {1'b0, code_point[30:24]};
            3'd5:    chunk = {7'b0, code_point[30]};
            default: chunk = '0;
        endcase
    end

    always_comb begin
        if (idx == '0) begin
            enc.data = lead | chunk;
        end else begin
            enc.data = CONT_MARK | (chunk & CONT_MASK);
        end
        enc.last = (idx == len - 3'd1);
    end

endmodule

@@ hw/rtl/utf8c_decoder.sv @@
// Decoder: sequence state and per-byte decode logic.
module utf8c_decoder
    import utf8c_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic [BYTE_W-1:0] byte_in,
    output dec_result_t       result
);

    logic [CP_W-1:0]  acc_reg, acc_next;
    logic [REM_W-1:0] rem_reg, rem_next;

    always_comb begin
        acc_next          = acc_reg;
        rem_next          = rem_reg;
        result.has_result = 1'b0;
        result.value      = '0;
        if (rem_reg == '0) begin
            if (byte_in >= LEAD_2 && byte_in < LEAD_3) begin
                acc_next = {26'b0, byte_in[4:0]};
                rem_next = 3'd1;
            end else if (byte_in >= LEAD_3 && byte_in < LEAD_4) begin
                acc_next = {27'b0, byte_in[3:0]};
                rem_next = 3'd2;
            end else if (byte_in >= LEAD_4 && byte_in < LEAD_5) begin
                acc_next = {28'b0, byte_in[2:0]};
                rem_next = 3'd3;
            end else if (byte_in >= LEAD_5 && byte_in < LEAD_6) begin
                acc_next = {29'b0, byte_in[1:0]};
                rem_next = 3'd4;
            end else if (byte_in >= LEAD_6 && byte_in <= LEAD_END) begin
                acc_next = {30'b0, byte_in[0]};
                rem_next = 3'd5;
            end else begin
                // not a lead byte: passed through as its own value
                result.has_result = 1'b1;
                result.value      = {{(CP_W-BYTE_W){1'b0}}, byte_in};
            end
        end else begin
            // bits above 30 fall off the top
            acc_next = {acc_reg[CP_W-7:0], byte_in[5:0]};
            rem_next = rem_reg - 3'd1;
            if (rem_reg == 3'd1) begin
                result.has_result = 1'b1;
                result.value      = acc_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
            rem_reg <= '0;
        end else if (en) begin
            acc_reg <= acc_next;
            rem_reg <= rem_next;
        end
    end

endmodule

@@ hw/rtl/utf8_codec_unit.sv @@
// Top level of the UTF-8 codec: input register, encode/decode logic, result register.
//
// Input channel s_*: one transfer per item. s_tuser is the operation
// (0 encode s_tdata code point, 1 decode one s_tdata byte).
// Result channel m_*: m_tuser is the kind (0 encoded byte, 1 decoded code
// point), m_tlast marks the final result of an input item.
// An accepted item sits in the input register; its first result is loaded into the
// result register once that register is free, and m_tvalid rises with that load.
// Throughput, while the result register is free: a decode item per cycle, an encode
// item one output byte per cycle (1 to 6), set by the encoder's single byte selector.
// A decode byte that only opens or extends a sequence gives no result.
// When m_tready is low the result register holds; the input register still
// takes an item while it is empty, then s_tready drops until the result is taken.
// Reset (aresetn low, synchronous) empties both registers and clears the
// decode sequence state; encode items never touch that state.
module utf8_codec_unit
    import utf8c_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // code_point[30:0], byte_in[38:31], zero pad
    input  logic                 s_tuser,  // op
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // byte_out[7:0], value_out[38:8], zero pad
    output logic                 m_tuser,  // kind
    output logic                 m_tlast
);

    logic              in_valid_reg, in_valid_next;
    logic              in_op_reg;
    logic [CP_W-1:0]   in_cp_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic [IDX_W-1:0]  enc_idx_reg, enc_idx_next;

    logic              out_valid_reg, out_valid_next;
    logic              out_kind_reg, out_kind_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic [CP_W-1:0]   out_value_reg, out_value_next;
    logic              out_last_reg, out_last_next;

    logic        advance;
    logic        item_done;
    logic        in_xfer;
    logic        out_load;
    enc_byte_t   enc;
    dec_result_t dec;

    utf8c_encoder u_enc (
        .code_point (in_cp_reg),
        .idx        (enc_idx_reg),
        .enc        (enc)
    );

    utf8c_decoder u_dec (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (advance && in_op_reg == OP_DECODE),
        .byte_in (in_byte_reg),
        .result  (dec)
    );

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign item_done = advance && (in_op_reg == OP_DECODE || enc.last);
    assign s_tready  = !in_valid_reg || item_done;
    assign in_xfer   = s_tvalid && s_tready;
    assign out_load  = advance && (in_op_reg == OP_ENCODE || dec.has_result);

    always_comb begin
        if (in_xfer) begin
            in_valid_next = 1'b1;
        end else if (item_done) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end

        if (item_done) begin
            enc_idx_next = '0;
        end else if (advance) begin
            enc_idx_next = enc_idx_reg + 3'd1;
        end else begin
            enc_idx_next = enc_idx_reg;
        end

        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end

        if (in_op_reg == OP_ENCODE) begin
            out_kind_next  = KIND_BYTE;
            out_byte_next  = enc.data;
            out_value_next = '0;
            out_last_next  = enc.last;
        end else begin
            out_kind_next  = KIND_VALUE;
            out_byte_next  = '0;
            out_value_next = dec.value;
            out_last_next  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            enc_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            enc_idx_reg   <= enc_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            in_op_reg   <= s_tuser;
            in_cp_reg   <= s_tdata[CP_W-1:0];
            in_byte_reg <= s_tdata[CP_W+BYTE_W-1:CP_W];
        end
        if (out_load) begin
            out_kind_reg  <= out_kind_next;
            out_byte_reg  <= out_byte_next;
            out_value_reg <= out_value_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(M_TDATA_W-BYTE_W-CP_W){1'b0}}, out_value_reg, out_byte_reg};

    // a byte position past zero only exists while an encode item is held
    assert property (@(posedge aclk) disable iff (!aresetn)
        enc_idx_reg != '0 |-> in_valid_reg && in_op_reg == OP_ENCODE)
        else $error("encode byte index set without a held encode item");

    assert property (@(posedge aclk) disable iff (!aresetn)
        enc_idx_reg < ENC_MAX_BYTES)
        else $error("encode byte index out of range");

    // decoded values are always a single, final result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_VALUE |-> m_tlast && m_tdata[BYTE_W-1:0] == '0)
        else $error("decoded result without last or with byte field set");

    // a held encode item that moves on must have produced a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_op_reg == OP_ENCODE |=> m_tvalid && m_tuser == KIND_BYTE)
        else $error("encode step lost its output byte");

endmodule
